/* src/cslks_pkg.sv */
// Package with the shared types and constants of the lowest-K score sum core.
package cslks_pkg;

   // Capacity of the sorted array that holds the kept optional scores.
   localparam int MAX_KEPT = 16;
   localparam int KEPT_IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int KEPT_CNT_W = $clog2(MAX_KEPT + 1);

   // Field widths.
   localparam int SCORE_W = 32;
   localparam int SUM_W = 40;
   localparam int K_W = 5;

   // Register file geometry.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register word indexes, taken from the word address bit of paddr.
   localparam logic REG_REQUIRED_OPTIONAL = 1'b0;

   // Saturation limits of the 40-bit sums.
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic                      is_optional;
      logic                      last;
   } req_payload_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] total_score;
      logic                    short_of_optional;
      logic                    saturated;
   } rsp_payload_type;

endpackage

/* src/constraint_score_lowest_k_sum_core.sv */
// Top level of the core that sums mandatory scores and the K lowest optional scores.
//
// The core takes one score beat per clock cycle while no last beat is
// stalled. A beat is first captured in an input register; from there it
// updates the mandatory sum, the sorted array of kept optional scores and the
// kept sum, all in one pass, and a last beat writes its total into the output
// register. The insert is a combinational compare-and-shift across the kept
// array, followed by the 40-bit total add. The output register lets the
// core keep accepting beats while a result waits; a new last beat stalls only
// when that register is still full. Register required_optional (K) sits at
// byte address 0 and may be changed only while the core is idle.
module constraint_score_lowest_k_sum_core (
   input  logic                               clock,
   input  logic                               reset,
   // Score beats in.
   input  logic                               req_valid,
   output logic                               req_ready,
   input  cslks_pkg::req_payload_type         req_payload,
   // Results out.
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output cslks_pkg::rsp_payload_type         rsp_payload,
   // Configuration port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cslks_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cslks_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cslks_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready
);

   localparam int MAX_KEPT = cslks_pkg::MAX_KEPT;
   localparam int IDX_W = cslks_pkg::KEPT_IDX_W;
   localparam int CNT_W = cslks_pkg::KEPT_CNT_W;
   localparam int SCORE_W = cslks_pkg::SCORE_W;
   localparam int SUM_W = cslks_pkg::SUM_W;
   localparam int K_W = cslks_pkg::K_W;

   // Configuration register.
   logic [K_W-1:0] k_ff, k_in;

   // Input register.
   logic                        s1_valid_ff, s1_valid_in;
   cslks_pkg::req_payload_type  s1_ff;

   // Pose state.
   logic signed [SUM_W-1:0]   mand_sum_ff, mand_sum_in;
   logic signed [SUM_W-1:0]   kept_sum_ff, kept_sum_in;
   logic [CNT_W-1:0]          kept_count_ff, kept_count_in;
   logic                      overflow_ff, overflow_in;
   logic signed [SCORE_W-1:0] kept_ff [MAX_KEPT];
   logic signed [SCORE_W-1:0] kept_in [MAX_KEPT];

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   cslks_pkg::rsp_payload_type  rsp_ff, rsp_in;

   // Datapath signals.
   logic                      out_free;
   logic                      s1_fire;
   logic [CNT_W-1:0]          cap;
   logic [CNT_W-1:0]          cnt_dec;
   logic [CNT_W-1:0]          cnt_base;
   logic                      drop;
   logic                      evict;
   logic                      do_insert;
   logic signed [SCORE_W-1:0] last_entry;
   logic [MAX_KEPT-1:0]       le;
   logic signed [SCORE_W-1:0] ins_entry [MAX_KEPT];
   logic signed [SUM_W-1:0]   kept_sum_upd;
   logic [CNT_W-1:0]          kept_count_upd;
   logic signed [SUM_W:0]     mand_wide;
   logic signed [SUM_W-1:0]   mand_upd;
   logic                      mand_hit;
   logic                      overflow_upd;
   logic signed [SUM_W:0]     total_wide;
   logic signed [SUM_W-1:0]   total_sat;
   logic                      total_hit;
   logic                      csr_write;

   // Register file access.
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == cslks_pkg::REG_REQUIRED_OPTIONAL)
                       ? {{(cslks_pkg::CSR_DATA_W-K_W){1'b0}}, k_ff}
                       : '0;

   always_comb begin
      k_in = k_ff;
      if (csr_write && (csr_paddr[2] == cslks_pkg::REG_REQUIRED_OPTIONAL)) begin
         k_in = csr_pwdata[K_W-1:0];
      end
   end

   // Handshake: a beat in the input register moves on unless it ends a pose
   // and the output register is still held.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_fire = s1_valid_ff && (!s1_ff.last || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;

   // Effective capacity is K clipped to the array size.
   always_comb begin
      if (int'(k_ff) > MAX_KEPT) begin
         cap = CNT_W'(MAX_KEPT);
      end else begin
         cap = CNT_W'(k_ff);
      end
   end

   // Decide whether an optional score is dropped or evicts the largest entry.
   assign cnt_dec = kept_count_ff - CNT_W'(1);
   assign last_entry = kept_ff[cnt_dec[IDX_W-1:0]];

   always_comb begin
      drop = 1'b0;
      evict = 1'b0;
      if (cap == '0) begin
         drop = 1'b1;
      end else if (kept_count_ff >= cap) begin
         if ((kept_count_ff == '0) || (s1_ff.score >= last_entry)) begin
            drop = 1'b1;
         end else begin
            evict = 1'b1;
         end
      end
   end

   assign do_insert = s1_ff.is_optional && !drop;
   assign cnt_base = evict ? cnt_dec : kept_count_ff;

   // Parallel compare against every kept entry and shift-insert.
   always_comb begin
      for (int i = 0; i < MAX_KEPT; i++) begin
         le[i] = (CNT_W'(i) < cnt_base) && (kept_ff[i] <= s1_ff.score);
      end
      for (int i = 0; i < MAX_KEPT; i++) begin
         if (le[i]) begin
            ins_entry[i] = kept_ff[i];
         end else if (i == 0) begin
            ins_entry[i] = s1_ff.score;
         end else if (le[i-1]) begin
            ins_entry[i] = s1_ff.score;
         end else begin
            ins_entry[i] = kept_ff[i-1];
         end
      end
   end

   // Kept sum and count after this beat.
   always_comb begin
      kept_sum_upd = kept_sum_ff;
      kept_count_upd = kept_count_ff;
      if (do_insert) begin
         kept_count_upd = cnt_base + CNT_W'(1);
         if (evict) begin
            kept_sum_upd = kept_sum_ff + SUM_W'(s1_ff.score) - SUM_W'(last_entry);
         end else begin
            kept_sum_upd = kept_sum_ff + SUM_W'(s1_ff.score);
         end
      end
   end

   // Saturating mandatory sum.
   always_comb begin
      mand_wide = (SUM_W+1)'(mand_sum_ff) + (SUM_W+1)'(s1_ff.score);
      mand_hit = 1'b0;
      mand_upd = mand_sum_ff;
      if (!s1_ff.is_optional) begin
         if (mand_wide[SUM_W] != mand_wide[SUM_W-1]) begin
            mand_hit = 1'b1;
            mand_upd = mand_wide[SUM_W] ? cslks_pkg::SUM_MIN : cslks_pkg::SUM_MAX;
         end else begin
            mand_upd = mand_wide[SUM_W-1:0];
         end
      end
      overflow_upd = overflow_ff || mand_hit;
   end

   // Saturating total for the end of the pose.
   always_comb begin
      total_wide = (SUM_W+1)'(mand_upd) + (SUM_W+1)'(kept_sum_upd);
      total_hit = (total_wide[SUM_W] != total_wide[SUM_W-1]);
      if (total_hit) begin
         total_sat = total_wide[SUM_W] ? cslks_pkg::SUM_MIN : cslks_pkg::SUM_MAX;
      end else begin
         total_sat = total_wide[SUM_W-1:0];
      end
   end

   // Next pose state: update on a moving beat, clear after the last one.
   always_comb begin
      mand_sum_in = mand_sum_ff;
      kept_sum_in = kept_sum_ff;
      kept_count_in = kept_count_ff;
      overflow_in = overflow_ff;
      for (int i = 0; i < MAX_KEPT; i++) begin
         kept_in[i] = kept_ff[i];
      end
      if (s1_fire) begin
         if (do_insert) begin
            for (int i = 0; i < MAX_KEPT; i++) begin
               kept_in[i] = ins_entry[i];
            end
         end
         if (s1_ff.last) begin
            mand_sum_in = '0;
            kept_sum_in = '0;
            kept_count_in = '0;
            overflow_in = 1'b0;
         end else begin
            mand_sum_in = mand_upd;
            kept_sum_in = kept_sum_upd;
            kept_count_in = kept_count_upd;
            overflow_in = overflow_upd;
         end
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      if (s1_fire && s1_ff.last) begin
         rsp_valid_in = 1'b1;
         rsp_in.total_score = total_sat;
         rsp_in.short_of_optional = (kept_count_upd < cap);
         rsp_in.saturated = total_hit || overflow_upd;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mand_sum_ff <= '0;
         kept_sum_ff <= '0;
         kept_count_ff <= '0;
         overflow_ff <= 1'b0;
      end else begin
         k_ff <= k_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mand_sum_ff <= mand_sum_in;
         kept_sum_ff <= kept_sum_in;
         kept_count_ff <= kept_count_in;
         overflow_ff <= overflow_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
      for (int i = 0; i < MAX_KEPT; i++) begin
         kept_ff[i] <= kept_in[i];
      end
   end

endmodule

/* src/cslks_checker.sv */
// Port-level checker for the lowest-K score sum core, with its bind.
module cslks_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  cslks_pkg::req_payload_type       req_payload,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  cslks_pkg::rsp_payload_type       rsp_payload,
   input  logic                             csr_pready
);

   // A held result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // No result right after reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A result that appears fresh comes from an accepted last beat that has passed the input and output registers.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_payload.last, 2))
      else $error("result without a matching last beat");

   // The register port never waits.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("register port stalled");

endmodule

bind constraint_score_lowest_k_sum_core cslks_checker u_cslks_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload),
   .csr_pready  (csr_pready)
);

/* sim/constraint_score_lowest_k_sum_core_tb.sv */
// Self-checking testbench for the lowest-K constraint score sum core.
module constraint_score_lowest_k_sum_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_BEATS = 650;
   localparam int PHASE_BEATS = 80;
   localparam int DRAIN_CYCLES = 6;

   // Holds the pose state of the core and the totals it should emit.
   class lowest_k_scoreboard;
      int unsigned k_reg;
      longint      mandatory_acc;
      longint      kept_acc;
      int          kept_sorted[$];
      bit          clamp_seen;
      cslks_pkg::rsp_payload_type expected_totals[$];
      int          failures;

      function new();
         k_reg = 0;
         failures = 0;
         clear_pose();
      endfunction

      function void clear_pose();
         mandatory_acc = 0;
         kept_acc = 0;
         kept_sorted.delete();
         clamp_seen = 1'b0;
      endfunction

      function int unsigned kept_limit();
         return (k_reg > cslks_pkg::MAX_KEPT) ? cslks_pkg::MAX_KEPT : k_reg;
      endfunction

      function longint clamp_sum(longint value, ref bit hit);
         if (value > longint'(cslks_pkg::SUM_MAX)) begin
            hit = 1'b1;
            return longint'(cslks_pkg::SUM_MAX);
         end
         if (value < longint'(cslks_pkg::SUM_MIN)) begin
            hit = 1'b1;
            return longint'(cslks_pkg::SUM_MIN);
         end
         return value;
      endfunction

      function void flag(string what);
         failures++;
         if (failures <= 10)
            $display("%s", what);
      endfunction

      // Keeps the smallest optional scores in ascending order.
      function void keep_optional(int score);
         int pos;
         if (kept_limit() == 0)
            return;
         if (kept_sorted.size() >= kept_limit()) begin
            if (kept_sorted.size() == 0 || score >= kept_sorted[$])
               return;
            kept_acc -= kept_sorted[$];
            void'(kept_sorted.pop_back());
         end
         pos = 0;
         while (pos < kept_sorted.size() && kept_sorted[pos] <= score)
            pos++;
         kept_sorted.insert(pos, score);
         kept_acc += score;
      endfunction

      // Applies one accepted score beat and queues a total on the last beat.
      function void note_beat(cslks_pkg::req_payload_type beat);
         bit hit;
         longint total;
         cslks_pkg::rsp_payload_type outcome;
         hit = 1'b0;
         if (beat.is_optional)
            keep_optional(int'(beat.score));
         else begin
            mandatory_acc = clamp_sum(mandatory_acc + longint'(beat.score), hit);
            if (hit)
               clamp_seen = 1'b1;
         end
         if (!beat.last)
            return;
         hit = 1'b0;
         total = clamp_sum(mandatory_acc + kept_acc, hit);
         outcome.total_score = total[cslks_pkg::SUM_W-1:0];
         outcome.short_of_optional = (kept_sorted.size() < kept_limit());
         outcome.saturated = hit || clamp_seen;
         expected_totals.push_back(outcome);
         clear_pose();
      endfunction

      // Compares one result beat with the oldest expected total.
      function void check_result(cslks_pkg::rsp_payload_type got);
         cslks_pkg::rsp_payload_type want;
         if (expected_totals.size() == 0) begin
            flag($sformatf("unexpected result: total %0d short %b sat %b",
                           got.total_score, got.short_of_optional, got.saturated));
            return;
         end
         want = expected_totals.pop_front();
         if (got.total_score !== want.total_score ||
             got.short_of_optional !== want.short_of_optional ||
             got.saturated !== want.saturated)
            flag($sformatf("mismatch: expected %0d %b %b, got %0d %b %b (total short sat)",
                           want.total_score, want.short_of_optional, want.saturated,
                           got.total_score, got.short_of_optional, got.saturated));
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   cslks_pkg::req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   cslks_pkg::rsp_payload_type rsp_payload;
   logic            csr_psel;
   logic            csr_penable;
   logic            csr_pwrite;
   logic [cslks_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [cslks_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [cslks_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic            csr_pready;

   lowest_k_scoreboard sb = new();
   int  cycle_count = 0;
   int  beat_count = 0;
   bit  sender_rush = 1'b0;
   bit  receiver_rush = 1'b0;

   constraint_score_lowest_k_sum_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** constraint_score_lowest_k_sum_core: FAILED **");
         $finish;
      end
   end

   // Sends one score beat after a random gap and records it once accepted.
   task automatic send_beat(input logic [cslks_pkg::SCORE_W-1:0] score, input bit opt,
                            input bit is_last);
      cslks_pkg::req_payload_type beat;
      int gap;
      beat.score = score;
      beat.is_optional = opt;
      beat.last = is_last;
      gap = sender_rush ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_beat(beat);
      beat_count++;
   endtask

   // Lets every pending total come out and the pipeline drain.
   task automatic settle_core();
      req_valid <= 1'b0;
      while (sb.expected_totals.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes K through the register port and reads it back.
   task automatic write_k(input int unsigned k);
      logic [cslks_pkg::CSR_DATA_W-1:0] word;
      word = $urandom();
      word[cslks_pkg::K_W-1:0] = k[cslks_pkg::K_W-1:0];
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {cslks_pkg::REG_REQUIRED_OPTIONAL, 2'b00};
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.k_reg = k & 5'h1F;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== cslks_pkg::CSR_DATA_W'(k[cslks_pkg::K_W-1:0]))
         sb.flag($sformatf("register readback: expected %0d, got %0h",
                           k[cslks_pkg::K_W-1:0], csr_prdata));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Draws a score in one of several value styles.
   function automatic logic [cslks_pkg::SCORE_W-1:0] pick_score(int style);
      case (style)
         0: return $urandom();
         1: return $urandom_range(0, 128) - 64;
         2: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0000_0001;
            endcase
         end
         default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   // One pose of random length, mix and value style, optionally left open.
   task automatic run_random_pose(input bit close_it);
      int len;
      int opt_pct;
      int style;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 80)
         len = $urandom_range(1, 20);
      else if (sel < 95)
         len = $urandom_range(21, 60);
      else
         len = 1;
      opt_pct = 25 * $urandom_range(0, 4);
      style = $urandom_range(0, 3);
      sender_rush = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++)
         send_beat(pick_score(style), $urandom_range(0, 99) < opt_pct,
                   close_it && (i == len - 1));
   endtask

   // A long pose of near-extreme scores that drives the sums into their limits.
   task automatic run_heavy_pose(input bit positive, input int n_mand, input int n_opt);
      int mand_left;
      int opt_left;
      bit opt;
      logic [cslks_pkg::SCORE_W-1:0] score;
      mand_left = n_mand;
      opt_left = n_opt;
      sender_rush = 1'b0;
      while (mand_left + opt_left > 0) begin
         opt = (opt_left > 0) && ($urandom_range(1, mand_left + opt_left) <= opt_left);
         if (opt)
            opt_left--;
         else
            mand_left--;
         score = positive ? $urandom_range(32'h7FFF_FFFF, 32'h7F00_0000)
                          : $urandom_range(32'h80FF_FFFF, 32'h8000_0000);
         send_beat(score, opt, (mand_left + opt_left) == 0);
      end
   endtask

   // Result side: random stalls, with stretches of constant readiness.
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = receiver_rush ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_result(rsp_payload);
         if ($urandom_range(0, 29) == 0)
            receiver_rush = !receiver_rush;
      end
   end

   // Main sequence: reset, directed poses, saturation poses, random phases.
   initial begin
      int k_plan[8];
      int phase;
      int phase_start;
      int random_start;
      k_plan = '{0, 1, 16, 17, 31, 2, 8, 15};
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extremes, equal and smaller scores against a full array of three.
      write_k(3);
      send_beat(32'h7FFF_FFFF, 1'b0, 1'b0);
      send_beat(32'h8000_0000, 1'b0, 1'b0);
      send_beat(32'd5, 1'b1, 1'b0);
      send_beat(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_beat(32'd5, 1'b1, 1'b0);
      send_beat(32'd5, 1'b1, 1'b0);
      send_beat(32'd3, 1'b1, 1'b0);
      send_beat(32'h8000_0000, 1'b1, 1'b0);
      send_beat(32'h7FFF_FFFF, 1'b1, 1'b0);
      send_beat(32'd0, 1'b0, 1'b1);
      // No optional scores at all, then too few of them.
      send_beat(32'hFFFF_FFFF, 1'b0, 1'b1);
      send_beat(32'd7, 1'b1, 1'b0);
      send_beat(32'd2, 1'b1, 1'b1);
      // K lowered while a pose is open: kept entries stay.
      send_beat(32'd10, 1'b1, 1'b0);
      send_beat(32'd20, 1'b1, 1'b0);
      send_beat(32'd30, 1'b1, 1'b0);
      settle_core();
      write_k(1);
      send_beat(32'd5, 1'b1, 1'b0);
      send_beat(32'd1, 1'b1, 1'b1);
      // K of zero ignores optional scores.
      settle_core();
      write_k(0);
      send_beat(32'd100, 1'b1, 1'b0);
      send_beat(32'd4, 1'b0, 1'b1);
      // K above the array capacity.
      settle_core();
      write_k(31);
      send_beat(32'hFFFF_0000, 1'b1, 1'b0);
      send_beat(32'h0001_0000, 1'b0, 1'b1);

      // Total clamps without mandatory overflow, then mandatory overflow both ways.
      settle_core();
      write_k(16);
      run_heavy_pose(1'b1, $urandom_range(240, 252), 20);
      run_heavy_pose(1'b0, $urandom_range(262, 290), 4);
      run_heavy_pose(1'b1, $urandom_range(262, 290), 0);

      // Random phases, each with its own K; some leave a pose open across the write.
      random_start = beat_count;
      phase = 0;
      while (beat_count - random_start < RANDOM_BEATS) begin
         settle_core();
         write_k((phase < 8) ? k_plan[phase] : $urandom_range(0, 31));
         phase_start = beat_count;
         while (beat_count - phase_start < PHASE_BEATS)
            run_random_pose(1'b1);
         if ($urandom_range(0, 2) == 0)
            run_random_pose(1'b0);
         phase++;
      end
      send_beat($urandom(), 1'b0, 1'b1);

      settle_core();
      if (sb.failures == 0)
         $display("** constraint_score_lowest_k_sum_core: PASSED **");
      else
         $display("** constraint_score_lowest_k_sum_core: FAILED **");
      $finish;
   end

endmodule

/* constraint_score_lowest_k_sum_core.f */
src/cslks_pkg.sv
src/constraint_score_lowest_k_sum_core.sv
src/cslks_checker.sv
sim/constraint_score_lowest_k_sum_core_tb.sv
